/* rtl/core/eis_pkg.sv */
// eis_pkg: shared constants, config bundle and sequencer state codes
// for the epipolar inlier scorer. No dependencies.
package eis_pkg;

  localparam int unsigned COORD_FRAC = 4;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned SCORE_W    = 40;
  localparam int unsigned ROW_W      = 60;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_F_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHI_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA = 3'd5;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [DIST_W-1:0]  THR_RESET = 32'd6554;
  localparam logic [DIST_W-1:0]  OFF_RESET = 32'd98304;
  localparam logic [DIST_W-1:0]  INV_RESET = 32'd65536;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] f_row;
    logic [DIST_W-1:0]     chi_threshold;
    logic [DIST_W-1:0]     score_offset;
    logic [DIST_W-1:0]     inv_sigma_sq;
  } cfg_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_LINE   = 11'b000_0000_0010,
    ST_DEN_A  = 11'b000_0000_0100,
    ST_DEN_B  = 11'b000_0000_1000,
    ST_NUM    = 11'b000_0001_0000,
    ST_SQ     = 11'b000_0010_0000,
    ST_SCALE  = 11'b000_0100_0000,
    ST_DIV    = 11'b000_1000_0000,
    ST_SCORE2 = 11'b001_0000_0000,
    ST_SCORE1 = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } back_state_e;

endpackage

/* rtl/core/eis_front.sv */
// eis_front: two-entry transaction queue in front of the compute engine.
// Depends on nothing.
module eis_front #(
  parameter int unsigned W = 65
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  output logic         s_ready_o,
  input  logic [W-1:0] s_data_i,
  input  logic         pop_i,
  output logic         avail_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign s_ready_o = (cnt_q != 2'd2);
  assign avail_o   = (cnt_q != 2'd0);
  assign push      = s_valid_i & s_ready_o;
  assign pop       = pop_i & avail_o;
  assign data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= s_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* rtl/core/eis_sermul.sv */
// eis_sermul: shift-add unsigned multiplier, one multiplier bit per cycle,
// with optional accumulate onto the previous product. No dependencies.
module eis_sermul #(
  parameter int unsigned XW = 112,
  parameter int unsigned YW = 56,
  parameter int unsigned PW = 144
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          acc_i,
  input  logic [XW-1:0] x_i,
  input  logic [YW-1:0] y_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  logic          busy_q;
  logic [PW-1:0] x_q, p_q;
  logic [YW-1:0] y_q;
  logic          y_zero;

  assign y_zero = (y_q == '0);
  assign done_o = busy_q & y_zero;
  assign prod_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && y_zero) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= PW'(x_i);
      y_q <= y_i;
      p_q <= acc_i ? p_q : '0;
    end else if (busy_q && !y_zero) begin
      if (y_q[0]) p_q <= p_q + x_q;
      x_q <= x_q << 1;
      y_q <= y_q >> 1;
    end
  end

endmodule

/* rtl/core/eis_div.sv */
// eis_div: restoring divider giving a saturated 32-bit Q16.16 quotient of
// num / (den << 2*COORD_FRAC). Depends on eis_pkg.
module eis_div #(
  parameter int unsigned NW = 144,
  parameter int unsigned DW = 77
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NW-1:0]             num_i,
  input  logic [DW-1:0]             den_i,
  output logic                      done_o,
  output logic [eis_pkg::DIST_W-1:0] quo_o
);

  localparam int unsigned TW = NW + 1;
  localparam logic [5:0]  CHECK = 6'd32;
  localparam logic [5:0]  TOP   = 6'd31;

  logic                       busy_q, done_q;
  logic [5:0]                 cnt_q;
  logic [TW-1:0]              rem_q, dsh_q;
  logic [eis_pkg::DIST_W-1:0] quo_q;
  logic                       ge, ge_top, checking;

  assign ge       = (rem_q >= dsh_q);
  assign ge_top   = (rem_q >= (dsh_q << 1));
  assign checking = (cnt_q == CHECK);
  assign done_o   = done_q;
  assign quo_o    = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= CHECK;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CHECK;
      end else if (busy_q) begin
        if (checking) begin
          if (ge_top) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= TOP;
          end
        end else if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= TW'(num_i);
      dsh_q <= TW'(den_i) << (2 * eis_pkg::COORD_FRAC + 31);
    end else if (busy_q) begin
      if (checking) begin
        if (ge_top) quo_q <= eis_pkg::DIST_MAX;
      end else begin
        if (ge) rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[eis_pkg::DIST_W-2:0], ge};
        dsh_q <= dsh_q >> 1;
      end
    end
  end

endmodule

/* rtl/core/eis_back.sv */
// eis_back: sequencer that forms both epipolar lines, the two scaled
// distances and the running score. Depends on eis_pkg, eis_sermul, eis_div.
module eis_back #(
  parameter int unsigned CW = 16,
  parameter int unsigned FW = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eis_pkg::cfg_t               cfg_i,
  input  logic                        avail_i,
  input  logic [4*CW:0]               item_i,
  output logic                        pop_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic                        inlier_o,
  output logic [eis_pkg::DIST_W-1:0]  dist_second_o,
  output logic [eis_pkg::DIST_W-1:0]  dist_first_o,
  output logic [eis_pkg::SCORE_W-1:0] score_o,
  output logic                        last_o
);

  localparam int unsigned LW   = FW + CW + 2;   // line coefficient, signed
  localparam int unsigned NW   = LW + CW + 2;   // numerator, signed
  localparam int unsigned XW   = 2 * NW;
  localparam int unsigned PW   = 2 * NW + 32;
  localparam int unsigned DENW = 2 * LW + 1;
  localparam logic signed [CW:0] ONE = (CW+1)'(1 << eis_pkg::COORD_FRAC);

  eis_pkg::back_state_e st_q, st_d;

  logic [4*CW:0]                item_q;
  logic [2:0]                   j_q;
  logic [1:0]                   t_q;
  logic                         side_q, run_q;
  logic signed [LW-1:0]         line_q [6];
  logic signed [NW-1:0]         mac_acc_q;
  logic [DENW-1:0]              den_q;
  logic [eis_pkg::DIST_W-1:0]   dist_q [2];
  logic [1:0]                   ok_q, pass_q;
  logic [eis_pkg::SCORE_W-1:0]  score_q;
  logic                         out_valid_q;

  logic [CW-1:0] u1, v1, u2, v2;
  logic          item_last;
  assign u1        = item_q[CW-1:0];
  assign v1        = item_q[2*CW-1:CW];
  assign u2        = item_q[3*CW-1:2*CW];
  assign v2        = item_q[4*CW-1:3*CW];
  assign item_last = item_q[4*CW];

  // coefficient fetch for the line phase
  logic [1:0]           row, col;
  logic signed [FW-1:0] coef;
  always_comb begin
    if (j_q < 3'd3) begin
      row = j_q[1:0];
      col = t_q;
    end else begin
      row = t_q;
      col = 2'(j_q - 3'd3);
    end
  end
  assign coef = cfg_i.f_row[row][col*FW +: FW];

  // single line-store read port
  logic [2:0]           rd_idx;
  logic signed [LW-1:0] line_rd;
  logic [LW-1:0]        line_mag;
  always_comb begin
    unique case (st_q)
      eis_pkg::ST_DEN_A: rd_idx = side_q ? 3'd3 : 3'd0;
      eis_pkg::ST_DEN_B: rd_idx = side_q ? 3'd4 : 3'd1;
      default:           rd_idx = 3'((side_q ? 3'd3 : 3'd0) + {1'b0, t_q});
    endcase
  end
  assign line_rd  = line_q[rd_idx];
  assign line_mag = line_rd[LW-1] ? LW'(-line_rd) : LW'(line_rd);

  // multiply-accumulate
  logic signed [LW-1:0]   mac_x;
  logic signed [CW:0]     mac_y;
  logic signed [LW+CW:0]  mac_p;
  logic signed [NW-1:0]   mac_pe, mac_sum;
  logic [CW-1:0]          pt_x, pt_y, ln_x, ln_y;
  assign pt_x = side_q ? u1 : u2;
  assign pt_y = side_q ? v1 : v2;
  assign ln_x = (j_q < 3'd3) ? u1 : u2;
  assign ln_y = (j_q < 3'd3) ? v1 : v2;
  always_comb begin
    if (st_q == eis_pkg::ST_LINE) begin
      mac_x = LW'(coef);
      case (t_q)
        2'd0:    mac_y = $signed({1'b0, ln_x});
        2'd1:    mac_y = $signed({1'b0, ln_y});
        default: mac_y = ONE;
      endcase
    end else begin
      mac_x = line_rd;
      case (t_q)
        2'd0:    mac_y = $signed({1'b0, pt_x});
        2'd1:    mac_y = $signed({1'b0, pt_y});
        default: mac_y = ONE;
      endcase
    end
  end
  assign mac_p   = mac_x * mac_y;
  assign mac_pe  = NW'(mac_p);
  assign mac_sum = ((t_q == 2'd0) ? NW'(0) : mac_acc_q) + mac_pe;

  logic [NW-1:0] num_mag;
  assign num_mag = mac_acc_q[NW-1] ? NW'(-mac_acc_q) : NW'(mac_acc_q);

  // shared multiplier and divider
  logic                       mul_start, mul_acc, mul_done, div_start, div_done;
  logic [XW-1:0]              mul_x;
  logic [NW-1:0]              mul_y;
  logic [PW-1:0]              prod;
  logic [eis_pkg::DIST_W-1:0] quo;

  always_comb begin
    mul_acc = 1'b0;
    mul_x   = XW'(line_mag);
    mul_y   = NW'(line_mag);
    case (st_q)
      eis_pkg::ST_DEN_B: mul_acc = 1'b1;
      eis_pkg::ST_SQ: begin
        mul_x = XW'(num_mag);
        mul_y = num_mag;
      end
      eis_pkg::ST_SCALE: begin
        mul_x = prod[XW-1:0];
        mul_y = NW'(cfg_i.inv_sigma_sq);
      end
      default: ;
    endcase
  end
  assign mul_start = !run_q && (st_q == eis_pkg::ST_DEN_A || st_q == eis_pkg::ST_DEN_B ||
                                st_q == eis_pkg::ST_SQ || st_q == eis_pkg::ST_SCALE);
  assign div_start = !run_q && (st_q == eis_pkg::ST_DIV);

  eis_sermul #(.XW(XW), .YW(NW), .PW(PW)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .acc_i(mul_acc), .x_i(mul_x), .y_i(mul_y),
    .done_o(mul_done), .prod_o(prod)
  );

  eis_div #(.NW(PW), .DW(DENW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(prod), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );

  // score step for the side picked by state
  logic                       sc_side, sc_pass;
  logic [eis_pkg::DIST_W-1:0] sc_dist, sc_add;
  logic [eis_pkg::SCORE_W:0]  sc_sum;
  assign sc_side = (st_q == eis_pkg::ST_SCORE1);
  assign sc_dist = dist_q[sc_side];
  assign sc_pass = ok_q[sc_side] && (sc_dist <= cfg_i.chi_threshold);
  assign sc_add  = (sc_pass && cfg_i.score_offset > sc_dist) ?
                   cfg_i.score_offset - sc_dist : '0;
  assign sc_sum  = {1'b0, score_q} + (eis_pkg::SCORE_W+1)'(sc_add);

  logic out_load, den_zero;
  assign out_load = (st_q == eis_pkg::ST_OUT) && (!out_valid_q || m_ready_i);
  assign den_zero = (prod[DENW-1:0] == '0);
  assign pop_o    = (st_q == eis_pkg::ST_IDLE) && avail_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      eis_pkg::ST_IDLE:   if (avail_i) st_d = eis_pkg::ST_LINE;
      eis_pkg::ST_LINE:   if (t_q == 2'd2 && j_q == 3'd5) st_d = eis_pkg::ST_DEN_A;
      eis_pkg::ST_DEN_A:  if (run_q && mul_done) st_d = eis_pkg::ST_DEN_B;
      eis_pkg::ST_DEN_B: begin
        if (run_q && mul_done) begin
          if (!den_zero)   st_d = eis_pkg::ST_NUM;
          else if (side_q) st_d = eis_pkg::ST_SCORE2;
          else             st_d = eis_pkg::ST_DEN_A;
        end
      end
      eis_pkg::ST_NUM:    if (t_q == 2'd2) st_d = eis_pkg::ST_SQ;
      eis_pkg::ST_SQ:     if (run_q && mul_done) st_d = eis_pkg::ST_SCALE;
      eis_pkg::ST_SCALE:  if (run_q && mul_done) st_d = eis_pkg::ST_DIV;
      eis_pkg::ST_DIV: begin
        if (run_q && div_done) st_d = side_q ? eis_pkg::ST_SCORE2 : eis_pkg::ST_DEN_A;
      end
      eis_pkg::ST_SCORE2: st_d = eis_pkg::ST_SCORE1;
      eis_pkg::ST_SCORE1: st_d = eis_pkg::ST_OUT;
      eis_pkg::ST_OUT:    if (out_load) st_d = eis_pkg::ST_IDLE;
      default:            st_d = eis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= eis_pkg::ST_IDLE;
      j_q         <= 3'd0;
      t_q         <= 2'd0;
      side_q      <= 1'b0;
      run_q       <= 1'b0;
      score_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (mul_start || div_start) run_q <= 1'b1;
      else if (st_d != st_q)      run_q <= 1'b0;
      unique case (st_q) inside
        eis_pkg::ST_IDLE: begin
          j_q    <= 3'd0;
          t_q    <= 2'd0;
          side_q <= 1'b0;
        end
        eis_pkg::ST_LINE: begin
          if (t_q == 2'd2) begin
            t_q <= 2'd0;
            j_q <= j_q + 3'd1;
          end else begin
            t_q <= t_q + 2'd1;
          end
        end
        eis_pkg::ST_DEN_B: begin
          if (run_q && mul_done && den_zero) side_q <= 1'b1;
        end
        eis_pkg::ST_NUM:   t_q <= (t_q == 2'd2) ? 2'd0 : t_q + 2'd1;
        eis_pkg::ST_DIV:   if (run_q && div_done) side_q <= 1'b1;
        eis_pkg::ST_SCORE2, eis_pkg::ST_SCORE1: begin
          score_q <= sc_sum[eis_pkg::SCORE_W] ? eis_pkg::SCORE_MAX
                                              : sc_sum[eis_pkg::SCORE_W-1:0];
        end
        eis_pkg::ST_OUT: begin
          if (out_load && item_last) score_q <= '0;
        end
        default: ;
      endcase
      if (out_load)                      out_valid_q <= 1'b1;
      else if (m_ready_i && out_valid_q) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= item_i;
    if (st_q == eis_pkg::ST_LINE || st_q == eis_pkg::ST_NUM) mac_acc_q <= mac_sum;
    if (st_q == eis_pkg::ST_LINE && t_q == 2'd2) line_q[j_q] <= mac_sum[LW-1:0];
    if (st_q == eis_pkg::ST_DEN_B && run_q && mul_done) begin
      den_q        <= prod[DENW-1:0];
      ok_q[side_q] <= !den_zero;
      if (den_zero) dist_q[side_q] <= eis_pkg::DIST_MAX;
    end
    if (st_q == eis_pkg::ST_DIV && run_q && div_done) dist_q[side_q] <= quo;
    if (st_q == eis_pkg::ST_SCORE2 || st_q == eis_pkg::ST_SCORE1) pass_q[sc_side] <= sc_pass;
    if (out_load) begin
      inlier_o      <= pass_q[0] & pass_q[1];
      dist_second_o <= dist_q[0];
      dist_first_o  <= dist_q[1];
      score_o       <= score_q;
      last_o        <= item_last;
    end
  end

  assign m_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_score_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_last) |=> (score_q == '0))
    else $error("score not cleared after last transaction");
  a_den_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == eis_pkg::ST_DEN_B && run_q && mul_done) |=>
      (st_q == eis_pkg::ST_NUM || st_q == eis_pkg::ST_DEN_A || st_q == eis_pkg::ST_SCORE2))
    else $error("bad exit from line norm step");
  a_both_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == eis_pkg::ST_SCORE2) |-> side_q)
    else $error("scoring before second side finished");
`endif

endmodule

/* rtl/core/epipolar_inlier_scorer.sv */
// Epipolar inlier scorer: symmetric epipolar distance test per correspondence.
// Processing time per transaction depends on the operands (shortest with zero line norms
// on both sides, longest with widest operands) and is set by the shift-add multiplier (one
// bit per cycle, four products per side) and the divider (once per side); one transaction in
// work at a time. A two-entry input queue and an output register decouple the stalls.
// Reset (rst_ni low, asynchronous) clears the queue and score and sets the configuration registers to defaults.
module epipolar_inlier_scorer #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_WIDTH  = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata, // x_first,y_first,x_second,y_second
  input  logic          s_axis_tlast,                      // last_pair
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,  // dist_in_second, dist_in_first, running_score
  output logic [0:0]    m_axis_tuser,  // inlier
  output logic          m_axis_tlast,  // last_result
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [eis_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [eis_pkg::ROW_W-1:0]       cfg_data_i
);

  localparam int unsigned ITEM_W = 4 * COORD_WIDTH + 1;

  // configuration registers
  eis_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.f_row         <= '0;
      cfg_q.chi_threshold <= eis_pkg::THR_RESET;
      cfg_q.score_offset  <= eis_pkg::OFF_RESET;
      cfg_q.inv_sigma_sq  <= eis_pkg::INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eis_pkg::CFG_F_ROW0:    cfg_q.f_row[0]      <= cfg_data_i;
        eis_pkg::CFG_F_ROW1:    cfg_q.f_row[1]      <= cfg_data_i;
        eis_pkg::CFG_F_ROW2:    cfg_q.f_row[2]      <= cfg_data_i;
        eis_pkg::CFG_CHI_THR:   cfg_q.chi_threshold <= cfg_data_i[eis_pkg::DIST_W-1:0];
        eis_pkg::CFG_SCORE_OFF: cfg_q.score_offset  <= cfg_data_i[eis_pkg::DIST_W-1:0];
        eis_pkg::CFG_INV_SIGMA: cfg_q.inv_sigma_sq  <= cfg_data_i[eis_pkg::DIST_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: queue transactions, back pops one when idle
  logic              avail, pop;
  logic [ITEM_W-1:0] item;

  eis_front #(.W(ITEM_W)) u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i({s_axis_tlast, s_axis_tdata[4*COORD_WIDTH-1:0]}),
    .pop_i(pop),
    .avail_o(avail),
    .data_o(item)
  );

  logic                        inlier, last;
  logic [eis_pkg::DIST_W-1:0]  d_second, d_first;
  logic [eis_pkg::SCORE_W-1:0] score;

  eis_back #(.CW(COORD_WIDTH), .FW(COEF_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q),
    .avail_i(avail),
    .item_i(item),
    .pop_o(pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .inlier_o(inlier),
    .dist_second_o(d_second),
    .dist_first_o(d_first),
    .score_o(score),
    .last_o(last)
  );

  assign m_axis_tdata = {score, d_first, d_second};
  assign m_axis_tuser = inlier;
  assign m_axis_tlast = last;

endmodule
